@@ src/ldrt_pkg.sv @@
// Shared types and constants for the longest distinct run tracker.
package ldrt_pkg;

  // Fixed field widths of the input and result words
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CH_VALUES = 256;
  localparam int unsigned BEST_W    = 17;

  // Input word: one byte of the string and its end mark
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } in_t;

  // Result word: best run so far, end echo, sticky overflow
  typedef struct packed {
    logic [BEST_W-1:0] best_length;
    logic              done_res;
    logic              overflow;
  } out_t;

endpackage

@@ src/ldrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ldrt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/longest_distinct_run_tracker.sv @@
// Top level of the longest distinct run tracker: table pipeline and result register.
//
// The block reads a string one byte per word and returns, for every byte, the length of the
// longest run of distinct bytes seen so far in the string, an echo of the end mark and a sticky
// overflow flag. One word is taken every cycle while the input is not stalled. The last-position
// table (a RAM with registered read) is read at the edge that takes a word into the update stage;
// when that stage fires, the window is updated, the table is written back and the result is
// loaded into the output register. A table write made while the next byte's read is in flight
// is forwarded to it.
// The per-entry valid bits are flip-flops cleared together at the end of each string, so no
// clearing pass is needed and the next string may start in the very next cycle. Input stall
// rises only while the output register holds a result that is being stalled and the update
// stage is full. Strings longer than MAX_LEN bytes set overflow; extra bytes change nothing else.
module longest_distinct_run_tracker
  import ldrt_pkg::*;
#(
  parameter longint unsigned MAX_LEN  = 65536,
  parameter int unsigned     ALPHABET = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);  // position, window start, best length
  localparam int unsigned SW = $clog2(MAX_LEN);      // stored position
  localparam int unsigned AW = $clog2(ALPHABET);     // table address
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN);

  typedef logic [AW-1:0] slot_lut_t [CH_VALUES];

  // Byte value to table entry, folding values beyond the alphabet
  function automatic slot_lut_t slot_table();
    slot_lut_t t;
    for (int i = 0; i < CH_VALUES; i++) begin
      t[i] = AW'(i % ALPHABET);
    end
    return t;
  endfunction

  localparam slot_lut_t SLOT_LUT = slot_table();

  // Pipeline and state registers
  logic                s1_valid_q, s1_valid_d;
  logic [AW-1:0]       s1_slot_q;
  logic                s1_last_q;
  logic                s1_fwd_q;
  logic [AW-1:0]       fwd_slot_q;
  logic [SW-1:0]       fwd_pos_q;
  logic [ALPHABET-1:0] seen_q;
  logic [PW-1:0]       window_q, window_d;
  logic [PW-1:0]       position_q, position_d;
  logic [PW-1:0]       best_q, best_d;
  logic                ovf_q, ovf_d;
  logic                out_valid_q;
  out_t                out_q;

  logic          in_accept;
  logic          s1_fire;
  logic          wr_en;
  logic [SW-1:0] rd_pos;
  logic [SW-1:0] prev_pos;
  logic [PW-1:0] after_pos;
  logic [PW-1:0] run_len;
  logic          at_limit;

  // Handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_fire);

  // Last-position table
  ldrt_ram #(
    .WIDTH(SW),
    .DEPTH(ALPHABET)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_slot_q),
    .wdata_i(position_q[SW-1:0]),
    .re_i   (in_accept),
    .raddr_i(SLOT_LUT[in_data_i.ch]),
    .rdata_o(rd_pos)
  );

  // Update stage: move the window, track the best run, record the position
  always_comb begin
    at_limit   = (position_q == POS_LIMIT);
    wr_en      = s1_fire && !at_limit;
    prev_pos   = (s1_fwd_q && (fwd_slot_q == s1_slot_q)) ? fwd_pos_q : rd_pos;
    after_pos  = PW'(prev_pos) + PW'(1);
    window_d   = window_q;
    position_d = position_q;
    best_d     = best_q;
    ovf_d      = ovf_q;
    run_len    = '0;
    if (at_limit) begin
      ovf_d = 1'b1;
    end else begin
      if (seen_q[s1_slot_q] && (after_pos > window_q)) begin
        window_d = after_pos;
      end
      run_len    = position_q - window_d + PW'(1);
      if (run_len > best_q) begin
        best_d = run_len;
      end
      position_d = position_q + PW'(1);
    end
  end

  // Hold pipeline control, string state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fwd_q    <= 1'b0;
      seen_q      <= '0;
      window_q    <= '0;
      position_q  <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_accept) begin
        s1_fwd_q <= wr_en;
      end
      if (s1_fire && s1_last_q) begin
        seen_q     <= '0;
        window_q   <= '0;
        position_q <= '0;
        best_q     <= '0;
        ovf_q      <= 1'b0;
      end else if (s1_fire) begin
        if (wr_en) begin
          seen_q[s1_slot_q] <= 1'b1;
        end
        window_q   <= window_d;
        position_q <= position_d;
        best_q     <= best_d;
        ovf_q      <= ovf_d;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: stage word, forwarded write, result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_slot_q <= SLOT_LUT[in_data_i.ch];
      s1_last_q <= in_data_i.last;
    end
    if (wr_en) begin
      fwd_slot_q <= s1_slot_q;
      fwd_pos_q  <= position_q[SW-1:0];
    end
    if (s1_fire) begin
      out_q.best_length <= BEST_W'(best_d);
      out_q.done_res    <= s1_last_q;
      out_q.overflow    <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input stalls only behind a blocked result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without output back-pressure");

  // End of string clears all string state
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (seen_q == '0 && position_q == '0 && best_q == '0 && !ovf_q))
    else $error("string state not cleared after final byte");

  // Window start never passes the position
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_q <= position_q)
    else $error("window start beyond position");

  // A recorded byte advances the position by one
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !s1_last_q) |=> (position_q == PW'($past(position_q) + PW'(1))))
    else $error("position did not advance by one");

  // The best run never shrinks within a string
  a_best_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !s1_last_q) |=> (best_q >= $past(best_q)))
    else $error("best length decreased within a string");

endmodule
